FILE: hdl/rmedf_pkg.sv
// Shared constants and types for the RM/EDF periodic task scheduler.
// Depends on nothing; imported by rm_edf_task_scheduler.
package rmedf_pkg;

	localparam int DEF_MAX_TASKS = 16;
	localparam int DEF_TIME_BITS = 32;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 16;
	localparam int LEN_W   = 32;
	localparam int MAX_RES = 3;

	// input operation codes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_LAST = 2'd2;
	localparam logic [1:0] OP_READ = 2'd3;

	// record kinds
	localparam logic [2:0] K_IDLE = 3'd0;
	localparam logic [2:0] K_PRE  = 3'd1;
	localparam logic [2:0] K_FIN  = 3'd2;
	localparam logic [2:0] K_LOST = 3'd3;
	localparam logic [2:0] K_KILL = 3'd4;
	localparam logic [2:0] K_CNT  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_COUNT  = 2'd1;

	typedef struct packed {
		logic              killed;
		logic [CNT_W-1:0]  completed;
		logic [CNT_W-1:0]  missed;
		logic [LEN_W-1:0]  units;
		logic [IDX_W-1:0]  idx;
		logic [2:0]        kind;
	} rec_t;

endpackage

FILE: hdl/rm_edf_task_scheduler.sv
// Periodic task scheduler (rate monotonic or earliest deadline first).
// Depends on rmedf_pkg. The task table is one synchronous memory.
//
// Usage:
//  - Input stream s_*: s_tuser is the operation (load, tick, last tick, read),
//    s_tdata carries task index, period and burst. One beat is taken only while
//    the block is idle.
//  - Output stream m_*: segment and counter records, m_tlast on the final
//    record that an input beat causes. Load beats produce no record.
//  - cfg_*: register writes (policy, task count), always ready; write only
//    while the block is idle.
// Sequence: a load is written from the idle state, a read passes through the
// counter state to the output beat. For N scanned tasks a tick makes one pass
// through the table memory to release tasks, one pass to pick the best ready
// task, then a read-modify-write of the running entry. The table read port
// delivers one entry per cycle. Up to two records per tick are then drained,
// one per cycle while m_tready is high.
// Reset: time, the run segment and the registers clear; the task table holds
// no defined contents until loaded. A stalled receiver holds the block in its
// drain state; no input is taken until all records are delivered.
module rm_edf_task_scheduler
	import rmedf_pkg::*;
#(
	parameter int MAX_TASKS = DEF_MAX_TASKS,
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // task_index[3:0], period[19:4], burst[35:20], zero pad
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // task_index_res[3:0], units[35:4], missed[51:36],
	                               // completed[67:52], killed[68], zero pad
	output logic [2:0]  m_tuser,   // kind[2:0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef struct packed {
		logic                 killed;
		logic [CNT_W-1:0]     done;
		logic [CNT_W-1:0]     missed;
		logic [TIME_BITS-1:0] dl;
		logic [15:0]          work;
		logic [15:0]          burst;
		logic [15:0]          period;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CNT, S_REL, S_PICK, S_SW, S_RRD, S_RWR, S_END, S_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic            policy_q;
	logic [4:0]      task_count_q;
	logic [CW-1:0]   cnt;

	// run state
	logic [TIME_BITS-1:0] now_q;
	logic                 busy_q;
	logic [IW-1:0]        run_q;
	logic [LEN_W-1:0]     len_q;

	// item and scan
	logic [1:0]           op_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CW-1:0]        scan_q;
	logic                 v_s1;
	logic [IW-1:0]        k_s1;
	logic                 found_q;
	logic [IW-1:0]        best_q;
	logic [TIME_BITS-1:0] bestv_q;

	// records
	rec_t       recs_q [MAX_RES];
	logic [1:0] rn_q;
	logic [1:0] rp_q;

	// table memory
	entry_t        mem [MAX_TASKS];
	entry_t        rd_q;
	logic [IW-1:0] rd_addr;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	entry_t        mem_wd;

	// combinational helpers
	logic                 s_acc;
	logic                 in_ok;
	logic                 issue;
	logic                 rel, lost, take, sw, fin;
	logic [TIME_BITS-1:0] pv;
	logic [15:0]          wl;
	logic [LEN_W-1:0]     len0, len1;
	logic                 emit;
	rec_t                 erec;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign in_ok     = 32'(s_tdata[3:0]) < 32'(MAX_TASKS);
	assign cnt = (32'(task_count_q) > 32'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(task_count_q);
	assign issue = scan_q < cnt;

	assign m_tvalid = (state_q == S_OUT);
	assign m_tuser  = recs_q[rp_q].kind;
	assign m_tlast  = (rp_q == rn_q - 2'd1);
	assign m_tdata  = {3'd0, recs_q[rp_q].killed, recs_q[rp_q].completed,
		recs_q[rp_q].missed, recs_q[rp_q].units, recs_q[rp_q].idx};

	// segment switch and run length update
	assign sw   = (found_q != busy_q) || (found_q && best_q != run_q);
	assign len0 = sw ? '0 : len_q;
	assign len1 = (&len0) ? len0 : len0 + 1'b1;

	// per-entry datapath
	always_comb begin
		rel    = (now_q != '0) && (now_q == rd_q.dl);
		lost   = 1'b0;
		take   = 1'b0;
		fin    = 1'b0;
		pv     = policy_q ? rd_q.dl : TIME_BITS'(rd_q.period);
		wl     = (rd_q.work != '0) ? rd_q.work - 16'd1 : 16'd0;
		mem_we = 1'b0;
		mem_wa = run_q;
		mem_wd = rd_q;
		rd_addr = IW'(s_tdata[3:0]);
		emit   = 1'b0;
		erec   = '0;
		case (state_q)
			S_IDLE: begin
				mem_wa = IW'(s_tdata[3:0]);
				mem_wd.period = s_tdata[19:4];
				mem_wd.burst  = s_tdata[35:20];
				mem_wd.work   = s_tdata[35:20];
				mem_wd.dl     = TIME_BITS'(s_tdata[19:4]);
				mem_wd.missed = '0;
				mem_wd.done   = '0;
				mem_wd.killed = 1'b0;
				mem_we = s_acc && (s_tuser == OP_LOAD) && in_ok;
			end
			S_CNT: begin
				emit      = 1'b1;
				erec.kind = K_CNT;
				erec.idx  = idx_q;
				if (32'(idx_q) < 32'(MAX_TASKS)) begin
					erec.missed    = rd_q.missed;
					erec.completed = rd_q.done;
					erec.killed    = rd_q.killed;
				end
			end
			S_REL: begin
				rd_addr = scan_q[IW-1:0];
				mem_wa  = k_s1;
				if (rel) begin
					if (rd_q.work != '0) begin
						if (!(&rd_q.missed)) mem_wd.missed = rd_q.missed + 1'b1;
						lost = busy_q && (run_q == k_s1);
					end
					mem_wd.work = rd_q.burst;
					mem_wd.dl   = rd_q.dl + TIME_BITS'(rd_q.period);
				end
				mem_we = v_s1 && rel;
				lost   = lost && v_s1;
				emit   = lost;
				erec.kind  = K_LOST;
				erec.idx   = IDX_W'(k_s1);
				erec.units = len_q;
			end
			S_PICK: begin
				rd_addr = scan_q[IW-1:0];
				take = v_s1 && (rd_q.work != '0) && (!found_q || pv < bestv_q);
			end
			S_SW: begin
				emit = sw && (len_q != '0);
				erec.kind  = busy_q ? K_PRE : K_IDLE;
				erec.idx   = busy_q ? IDX_W'(run_q) : '0;
				erec.units = len_q;
			end
			S_RRD: rd_addr = run_q;
			S_RWR: begin
				fin = (wl == '0);
				mem_wd.work = wl;
				if (fin && !(&rd_q.done)) mem_wd.done = rd_q.done + 1'b1;
				if (!fin && op_q == OP_LAST) mem_wd.killed = 1'b1;
				mem_we = 1'b1;
				emit   = fin;
				erec.kind  = K_FIN;
				erec.idx   = IDX_W'(run_q);
				erec.units = len_q;
			end
			S_END: begin
				emit = (op_q == OP_LAST) && (len_q != '0);
				erec.kind  = busy_q ? K_KILL : K_IDLE;
				erec.idx   = busy_q ? IDX_W'(run_q) : '0;
				erec.units = len_q;
			end
			default: ;
		endcase
	end

	// task table memory
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[rd_addr];
	end

	// record buffer payload
	always_ff @(posedge clk) begin
		if (emit) recs_q[rn_q] <= erec;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q     <= 1'b0;
			task_count_q <= 5'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_POLICY: policy_q     <= cfg_data[0];
				REG_COUNT:  task_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			now_q   <= '0;
			busy_q  <= 1'b0;
			run_q   <= '0;
			len_q   <= '0;
			op_q    <= OP_LOAD;
			idx_q   <= '0;
			scan_q  <= '0;
			v_s1    <= 1'b0;
			k_s1    <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			bestv_q <= '0;
			rn_q    <= '0;
			rp_q    <= '0;
		end else begin
			if (emit) rn_q <= rn_q + 2'd1;
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						op_q   <= s_tuser;
						idx_q  <= s_tdata[3:0];
						scan_q <= '0;
						v_s1   <= 1'b0;
						case (s_tuser)
							OP_READ: state_q <= S_CNT;
							OP_TICK, OP_LAST: state_q <= S_REL;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CNT: state_q <= S_OUT;
				S_REL, S_PICK: begin
					v_s1 <= issue;
					k_s1 <= scan_q[IW-1:0];
					if (issue) scan_q <= scan_q + 1'b1;
					if (lost) begin
						len_q  <= '0;
						busy_q <= 1'b0;
					end
					if (take) begin
						found_q <= 1'b1;
						best_q  <= k_s1;
						bestv_q <= pv;
					end
					if (!issue && !v_s1) begin
						scan_q  <= '0;
						found_q <= (state_q == S_PICK) ? found_q : 1'b0;
						state_q <= (state_q == S_REL) ? S_PICK : S_SW;
					end
				end
				S_SW: begin
					len_q <= len1;
					if (sw) begin
						busy_q <= found_q;
						run_q  <= found_q ? best_q : '0;
					end
					state_q <= (sw ? found_q : busy_q) ? S_RRD : S_END;
				end
				S_RRD: state_q <= S_RWR;
				S_RWR: begin
					if (fin) begin
						len_q  <= '0;
						busy_q <= 1'b0;
					end
					state_q <= S_END;
				end
				S_END: begin
					if (op_q == OP_LAST) begin
						now_q  <= '0;
						busy_q <= 1'b0;
						run_q  <= '0;
						len_q  <= '0;
					end else begin
						now_q <= now_q + 1'b1;
					end
					state_q <= (emit || rn_q != '0) ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (m_tready) begin
						if (m_tlast) begin
							rp_q    <= '0;
							rn_q    <= '0;
							state_q <= S_IDLE;
						end else begin
							rp_q <= rp_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// no input beat is taken while records are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while records pending");

	// draining only happens with at least one record buffered
	a_out_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (rn_q != 2'd0 && rp_q < rn_q))
		else $error("drain with empty record buffer");

	// final beat returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("block not idle after final record");

	// a last tick always leaves the run segment closed
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END && op_q == OP_LAST) |=> (now_q == '0 && !busy_q && len_q == '0))
		else $error("run state not cleared after last tick");

endmodule

FILE: dv/rm_edf_task_scheduler_tb.sv
// Self-checking testbench for rm_edf_task_scheduler: directed table, then random
// periodic task sets under RM and EDF, checked against an in-bench schedule model.
// Depends on rmedf_pkg and the rm_edf_task_scheduler RTL.
`timescale 1ns / 100ps

module rm_edf_task_scheduler_tb;
	import rmedf_pkg::*;

	localparam int NT = 16;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [4:0]  cfg_data;

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  idx;
		logic [31:0] units;
		logic [15:0] missed;
		logic [15:0] completed;
		logic        killed;
		logic        last;
	} sched_rec_t;

	typedef struct {
		logic [1:0]  op;
		logic [3:0]  idx;
		logic [15:0] period;
		logic [15:0] burst;
		bit          has_exp;
		logic [2:0]  exp_kind;
		logic [15:0] exp_missed;
	} dir_row_t;

	rm_edf_task_scheduler dut (.*);

	// schedule model state
	logic        pol;
	logic [4:0]  ntasks;
	logic [15:0] t_period [NT];
	logic [15:0] t_burst [NT];
	logic [15:0] t_left [NT];
	logic [31:0] t_dline [NT];
	logic [15:0] t_missed [NT];
	logic [15:0] t_done [NT];
	logic        t_killed [NT];
	logic [31:0] now_t;
	bit          busy;
	logic [3:0]  run_task;
	logic [31:0] run_len;

	sched_rec_t  pending_recs[$];
	sched_rec_t  new_recs[$];
	int          errors, n_items, n_recs;
	bit          hold_off;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#50ms;
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string what, input sched_rec_t got, input sched_rec_t exp);
		errors++;
		$display("MISMATCH %s: got %p exp %p", what, got, exp);
	endtask

	function automatic void push_rec(input logic [2:0] k, input logic [3:0] i, input logic [31:0] u);
		sched_rec_t r;
		r = '0;
		r.kind = k;
		r.idx = i;
		r.units = u;
		new_recs.push_back(r);
	endfunction

	function automatic void close_segment(input logic [2:0] busy_kind);
		if (run_len != 0) begin
			if (busy)
				push_rec(busy_kind, run_task, run_len);
			else
				push_rec(K_IDLE, 4'd0, run_len);
		end
	endfunction

	function automatic void advance_time_unit();
		int cnt;
		bit found;
		logic [3:0] best;
		logic [31:0] best_v, v;
		cnt = (ntasks > NT) ? NT : ntasks;
		found = 0;
		best = '0;
		best_v = '0;
		// releases
		for (int i = 0; i < cnt; i++) begin
			if (now_t != 0 && now_t == t_dline[i]) begin
				if (t_left[i] != 0) begin
					if (t_missed[i] != 16'hFFFF) t_missed[i]++;
					if (busy && run_task == i) begin
						push_rec(K_LOST, i[3:0], run_len);
						run_len = 0;
						busy = 0;
					end
				end
				t_left[i] = t_burst[i];
				t_dline[i] = t_dline[i] + t_period[i];
			end
		end
		// pick
		for (int i = 0; i < cnt; i++) begin
			if (t_left[i] != 0) begin
				v = pol ? t_dline[i] : {16'd0, t_period[i]};
				if (!found || v < best_v) begin
					found = 1;
					best = i[3:0];
					best_v = v;
				end
			end
		end
		if (found != busy || (found && best != run_task)) begin
			close_segment(K_PRE);
			busy = found;
			run_task = found ? best : 4'd0;
			run_len = 0;
		end
		if (run_len != 32'hFFFFFFFF) run_len++;
		if (busy) begin
			if (t_left[run_task] != 0) t_left[run_task]--;
			if (t_left[run_task] == 0) begin
				if (t_done[run_task] != 16'hFFFF) t_done[run_task]++;
				push_rec(K_FIN, run_task, run_len);
				run_len = 0;
				busy = 0;
			end
		end
	endfunction

	function automatic void predict_item(input logic [1:0] op, input logic [3:0] i,
			input logic [15:0] p, input logic [15:0] b);
		sched_rec_t r;
		new_recs.delete();
		case (op)
			OP_LOAD: begin
				t_period[i] = p;
				t_burst[i] = b;
				t_left[i] = b;
				t_dline[i] = {16'd0, p};
				t_missed[i] = 0;
				t_done[i] = 0;
				t_killed[i] = 0;
			end
			OP_READ: begin
				r = '0;
				r.kind = K_CNT;
				r.idx = i;
				r.missed = t_missed[i];
				r.completed = t_done[i];
				r.killed = t_killed[i];
				new_recs.push_back(r);
			end
			default: begin
				advance_time_unit();
				if (op == OP_LAST) begin
					if (run_len != 0 && busy) t_killed[run_task] = 1;
					close_segment(K_KILL);
					now_t = 0;
					busy = 0;
					run_task = 0;
					run_len = 0;
				end else begin
					now_t = now_t + 1;
				end
			end
		endcase
		if (new_recs.size() > 0) new_recs[new_recs.size()-1].last = 1'b1;
		foreach (new_recs[k]) pending_recs.push_back(new_recs[k]);
	endfunction

	// send one beat; random gap before it, valid stays up for back-to-back beats
	task automatic send_item(input logic [1:0] op, input logic [3:0] i,
			input logic [15:0] p, input logic [15:0] b);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'd0, b, p, i};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(op, i, p, b);
		n_items++;
	endtask

	// valid drops between writes, so consecutive writes stay apart
	task automatic write_reg(input logic [1:0] ri, input logic [4:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (ri == REG_POLICY) pol = val[0];
		else ntasks = val;
	endtask

	task automatic drain_wait();
		int guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (pending_recs.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	// output side: random stalls, plus a long hold-off on request
	initial begin
		int stall;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			stall = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 1);
			if ($urandom_range(0, 2) == 0) stall = 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// record checker
	always @(posedge clk) begin
		sched_rec_t got, exp;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.idx = m_tdata[3:0];
			got.units = m_tdata[35:4];
			got.missed = m_tdata[51:36];
			got.completed = m_tdata[67:52];
			got.killed = m_tdata[68];
			got.last = m_tlast;
			n_recs++;
			if (pending_recs.size() == 0) begin
				report_mismatch("unexpected record", got, got);
			end else begin
				exp = pending_recs.pop_front();
				if (got != exp) report_mismatch("record fields", got, exp);
			end
		end
	end

	initial begin
		dir_row_t dir[$];
		dir_row_t row;
		int ntk, nt;
		sched_rec_t chk;

		errors = 0; n_items = 0; n_recs = 0; hold_off = 0;
		s_tvalid = 0; s_tdata = '0; s_tuser = OP_LOAD;
		cfg_valid = 0; cfg_index = REG_POLICY; cfg_data = '0;
		pol = 0; ntasks = 1; now_t = 0; busy = 0; run_task = 0; run_len = 0;
		for (int i = 0; i < NT; i++) begin
			t_period[i] = 0; t_burst[i] = 0; t_left[i] = 0; t_dline[i] = 0;
			t_missed[i] = 0; t_done[i] = 0; t_killed[i] = 0;
		end
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every entry loaded, entries 0 and 15 at extremes, ticks, misses, reads
		write_reg(REG_COUNT, 5'd16);
		write_reg(REG_POLICY, 5'd0);
		dir.push_back('{OP_LOAD, 4'd0, 16'd65535, 16'd65535, 0, 0, 0});
		dir.push_back('{OP_READ, 4'd0, 16'd0, 16'd0, 1, K_CNT, 16'd0});
		dir.push_back('{OP_LOAD, 4'd15, 16'd1, 16'd1, 0, 0, 0});
		for (int i = 1; i < 15; i++)
			dir.push_back('{OP_LOAD, i[3:0], 16'd3, 16'd2, 0, 0, 0});
		dir.push_back('{OP_TICK, 4'd0, 16'd0, 16'd0, 0, 0, 0});
		dir.push_back('{OP_TICK, 4'd0, 16'd0, 16'd0, 0, 0, 0});
		dir.push_back('{OP_TICK, 4'd0, 16'd0, 16'd0, 0, 0, 0});
		dir.push_back('{OP_LAST, 4'd0, 16'd0, 16'd0, 0, 0, 0});
		dir.push_back('{OP_READ, 4'd15, 16'd0, 16'd0, 0, 0, 0});
		dir.push_back('{OP_READ, 4'd0, 16'd0, 16'd0, 0, 0, 0});
		foreach (dir[k]) begin
			row = dir[k];
			send_item(row.op, row.idx, row.period, row.burst);
			if (row.has_exp) begin
				chk = pending_recs[pending_recs.size()-1];
				if (chk.kind != row.exp_kind || chk.missed != row.exp_missed)
					report_mismatch("directed row", chk, chk);
			end
		end
		drain_wait();

		// random phases: small task sets, a full set of 16 in the last phase, mostly ticks
		for (int ph = 0; ph < 6; ph++) begin
			ntk = (ph == 5) ? 16 : $urandom_range(1, 5);
			write_reg(REG_POLICY, {4'd0, ph[0]});
			write_reg(REG_COUNT, ntk[4:0]);
			for (int i = 0; i < ntk; i++) begin
				logic [15:0] p;
				p = 16'($urandom_range(2, 12));
				if ($urandom_range(0, 9) == 0) p = 16'($urandom_range(1, 65535));
				send_item(OP_LOAD, i[3:0], p, 16'($urandom_range(1, p)));
			end
			nt = $urandom_range(20, 35);
			if (ph == 2) hold_off = 1;
			for (int k = 0; k < nt; k++) begin
				int r;
				r = $urandom_range(0, 9);
				if (r == 0)
					send_item(OP_READ, 4'($urandom_range(0, ntk - 1)), 16'($urandom),
						16'($urandom));
				else
					send_item(OP_TICK, 4'($urandom), 16'($urandom), 16'($urandom));
			end
			send_item(OP_LAST, 4'($urandom), 16'($urandom), 16'($urandom));
			for (int i = 0; i < ntk; i++)
				if ($urandom_range(0, 1)) send_item(OP_READ, i[3:0], 16'd0, 16'd0);
			drain_wait();
		end

		$display("tb: %0d input beats, %0d records checked, RM and EDF, 1..16 tasks",
			n_items, n_recs);
		if (errors == 0 && pending_recs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: rm_edf_task_scheduler.f
hdl/rmedf_pkg.sv
hdl/rm_edf_task_scheduler.sv
dv/rm_edf_task_scheduler_tb.sv
